### rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every rising edge outside of reset.
`define UCFP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Check that cond is never true outside of reset.
`define UCFP_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define UCFP_ASSERT(label, clk, rst_n, prop)
`define UCFP_NEVER(label, clk, rst_n, cond)

`endif

`endif

### rtl/ucfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ucfp_pkg;

  // Default depth of the data byte store.
  localparam int MAX_DATA_BYTES = 3;

  // Frame markers.
  localparam logic [7:0] START_MARK = 8'hF0;
  localparam logic [7:0] END_MARK   = 8'hD7;

  // Known command codes.
  localparam logic [7:0] CMD_2A = 8'h2A;
  localparam logic [7:0] CMD_2B = 8'h2B;
  localparam logic [7:0] CMD_3A = 8'h3A;
  localparam logic [7:0] CMD_3B = 8'h3B;
  localparam logic [7:0] CMD_4A = 8'h4A;
  localparam logic [7:0] CMD_4B = 8'h4B;
  localparam logic [7:0] CMD_4C = 8'h4C;
  localparam logic [7:0] CMD_5A = 8'h5A;
  localparam logic [7:0] CMD_5B = 8'h5B;
  localparam logic [7:0] CMD_5C = 8'h5C;
  localparam logic [7:0] CMD_6A = 8'h6A;
  localparam logic [7:0] CMD_6B = 8'h6B;

  typedef struct packed {
    logic       known;
    logic [1:0] len;
  } len_info_t;

  typedef struct packed {
    logic [7:0] command;
    logic       frame_status;
    logic [1:0] data_count;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [7:0] data_third;
    logic [7:0] received_checksum;
  } result_t;

  // Data length of a command code.
  function automatic len_info_t length_of(input logic [7:0] cmd);
    len_info_t info;
    info = '{known: 1'b1, len: 2'd0};
    unique case (cmd) inside
      CMD_2A, CMD_2B, CMD_3A, CMD_3B:                 info.len = 2'd2;
      CMD_4A, CMD_4C:                                 info.len = 2'd1;
      CMD_4B, CMD_5A, CMD_5B, CMD_5C, CMD_6A, CMD_6B: info.len = 2'd3;
      default:                                        info.known = 1'b0;
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

### rtl/ucfp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ucfp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            byte_valid,
  output logic [7:0]      byte_data,
  input  wire logic       byte_take
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       load;

  // Hold the byte until the parser takes it; refill in the same cycle.
  assign in_stall   = valid_r && !byte_take;
  assign load       = in_valid && !in_stall;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || byte_take) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

### rtl/ucfp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ucfp_parser #(
  parameter int MAX_DATA_BYTES = ucfp_pkg::MAX_DATA_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid,
  input  wire logic [7:0] byte_data,
  output logic            byte_take,
  input  wire logic       res_ready,
  output logic            res_valid,
  output ucfp_pkg::result_t res_data
);

  localparam int IdxW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COMMAND,
    PH_DATA,
    PH_CHECKSUM,
    PH_END
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [1:0] exp_r, exp_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       inv_r, inv_nxt;
  logic [7:0] csum_r, csum_nxt;
  logic [7:0] store_r [MAX_DATA_BYTES];
  logic       wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [7:0] rd_data [3];

  assign byte_take = byte_valid && res_ready;
  assign wr_idx    = IdxW'(idx_r);

  always_comb begin
    ucfp_pkg::len_info_t info;
    logic [1:0]          len;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    exp_nxt   = exp_r;
    idx_nxt   = idx_r;
    inv_nxt   = inv_r;
    csum_nxt  = csum_r;
    wr_en     = 1'b0;
    res_valid = 1'b0;
    info      = ucfp_pkg::length_of(byte_data);
    len       = info.len;
    if (int'(info.len) > MAX_DATA_BYTES) begin
      len = 2'(MAX_DATA_BYTES);
    end
    if (byte_take) begin
      unique case (phase_r)
        PH_COMMAND: begin
          cmd_nxt = byte_data;
          idx_nxt = 2'd0;
          if (!info.known) begin
            inv_nxt   = 1'b1;
            exp_nxt   = 2'd0;
            phase_nxt = PH_CHECKSUM;
          end else begin
            exp_nxt   = len;
            phase_nxt = (len == 2'd0) ? PH_CHECKSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          wr_en   = int'(idx_r) < MAX_DATA_BYTES;
          idx_nxt = idx_r + 2'd1;
          if (idx_nxt >= exp_r) begin
            phase_nxt = PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: begin
          csum_nxt  = byte_data;
          phase_nxt = PH_END;
        end
        PH_END: begin
          if (byte_data == ucfp_pkg::END_MARK) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (byte_data == ucfp_pkg::START_MARK) begin
            phase_nxt = PH_COMMAND;
            inv_nxt   = 1'b0;
            exp_nxt   = 2'd0;
            idx_nxt   = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= '0;
      exp_r   <= '0;
      idx_r   <= '0;
      inv_r   <= 1'b0;
      csum_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      exp_r   <= exp_nxt;
      idx_r   <= idx_nxt;
      inv_r   <= inv_nxt;
      csum_r  <= csum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= byte_data;
    end
  end

  // Zero any byte slot beyond the captured count or the store depth.
  for (genvar k = 0; k < 3; k++) begin : g_rd
    if (k < MAX_DATA_BYTES) begin : g_have
      assign rd_data[k] = (2'(k) < exp_r) ? store_r[k] : 8'h00;
    end else begin : g_none
      assign rd_data[k] = 8'h00;
    end
  end

  always_comb begin
    res_data.command           = cmd_r;
    res_data.frame_status      = inv_r;
    res_data.data_count        = exp_r;
    res_data.data_first        = rd_data[0];
    res_data.data_second       = rd_data[1];
    res_data.data_third        = rd_data[2];
    res_data.received_checksum = csum_r;
  end

  `UCFP_ASSERT(a_data_in_range, clk, rst_n, (phase_r == PH_DATA) |-> (idx_r < exp_r))
  `UCFP_ASSERT(a_invalid_no_data, clk, rst_n, inv_r |-> (exp_r == 2'd0))
  `UCFP_ASSERT(a_emit_from_end, clk, rst_n, res_valid |=> (phase_r == PH_IDLE))

endmodule

`default_nettype wire

### rtl/ucfp_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ucfp_out_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire ucfp_pkg::result_t push_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ucfp_pkg::result_t      out_data
);

  logic              out_v_r;
  ucfp_pkg::result_t out_d_r;
  logic              sk_v_r;
  ucfp_pkg::result_t sk_d_r;
  logic              push;
  logic              advance;

  assign push_ready = !sk_v_r;
  assign push       = push_valid && push_ready;
  assign advance    = !out_v_r || !out_stall;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (advance) begin
      out_v_r <= sk_v_r || push;
      sk_v_r  <= 1'b0;
    end else if (push) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_d_r <= sk_v_r ? sk_d_r : push_data;
    end else if (push) begin
      sk_d_r <= push_data;
    end
  end

  `UCFP_NEVER(a_skid_needs_out, clk, rst_n, sk_v_r && !out_v_r)
  `UCFP_ASSERT(a_skid_fill_on_stall, clk, rst_n, $rose(sk_v_r) |-> $past(out_v_r && out_stall))

endmodule

`default_nettype wire

### rtl/uart_command_frame_parser_core.sv
// Timing: a received byte is registered in the input register before the
//   parser takes it; a frame result is registered after its end marker byte.
// Throughput: one byte per cycle while the output skid slot is not full.
// Reset: rst_n is synchronous, active low; it clears the parser state and
//   all valid flags. The data byte store is not reset.
`timescale 1ns / 1ps
`default_nettype none

module uart_command_frame_parser_core #(
  parameter int MAX_DATA_BYTES = ucfp_pkg::MAX_DATA_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Received byte channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // Frame result channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_command,
  output logic            out_frame_status,
  output logic [1:0]      out_data_count,
  output logic [7:0]      out_data_first,
  output logic [7:0]      out_data_second,
  output logic [7:0]      out_data_third,
  output logic [7:0]      out_received_checksum
);

  logic              byte_valid;
  logic [7:0]        byte_data;
  logic              byte_take;
  logic              res_ready;
  logic              res_valid;
  ucfp_pkg::result_t res_data;
  ucfp_pkg::result_t out_data;

  // Input register: hold one received byte for the parser.
  ucfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take)
  );

  // Parser: advance the frame state on each byte, emit on the end marker.
  // It stalls only while the output skid slot is full, so the upstream
  // stall never waits on out_stall combinationally.
  ucfp_parser #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  // Result register with a skid slot: hold a finished frame while
  // the parser keeps taking bytes.
  ucfp_out_skid u_out_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_ready (res_ready),
    .push_data  (res_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Drive the result fields from the output register.
  assign out_command           = out_data.command;
  assign out_frame_status      = out_data.frame_status;
  assign out_data_count        = out_data.data_count;
  assign out_data_first        = out_data.data_first;
  assign out_data_second       = out_data.data_second;
  assign out_data_third        = out_data.data_third;
  assign out_received_checksum = out_data.received_checksum;

endmodule

`default_nettype wire
